// ----- rtl/dirac_sequence_header_parser_defines.svh -----
// Assertion macros for the sequence header parser checker.
// No dependencies; taken in by the checker file.
`ifndef DIRAC_SEQUENCE_HEADER_PARSER_DEFINES_SVH
`define DIRAC_SEQUENCE_HEADER_PARSER_DEFINES_SVH

// Checked only outside reset.
`define DSH_ASSERT_ON(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define DSH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/dsh_pkg.sv -----
// Shared types, constants and tables of the sequence header parser.
// No dependencies.
`default_nettype none
package dsh_pkg;

  localparam int unsigned HEADER_SKIP_BYTES = 13;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FORMAT = 2'd1;
  localparam logic [1:0] STAT_RATE   = 2'd2;
  localparam logic [1:0] STAT_ZERO   = 2'd3;

  // Parse steps
  localparam logic [5:0] P_SKIP        = 6'd0;
  localparam logic [5:0] P_VERSION     = 6'd1;
  localparam logic [5:0] P_FORMAT      = 6'd5;
  localparam logic [5:0] P_SIZE_FLAG   = 6'd6;
  localparam logic [5:0] P_WIDTH       = 6'd7;
  localparam logic [5:0] P_HEIGHT      = 6'd8;
  localparam logic [5:0] P_CHROMA_FLAG = 6'd9;
  localparam logic [5:0] P_CHROMA      = 6'd10;
  localparam logic [5:0] P_SCAN_FLAG   = 6'd11;
  localparam logic [5:0] P_SCAN        = 6'd12;
  localparam logic [5:0] P_RATE_FLAG   = 6'd13;
  localparam logic [5:0] P_RATE_IDX    = 6'd14;
  localparam logic [5:0] P_RATE_NUM    = 6'd15;
  localparam logic [5:0] P_RATE_DEN    = 6'd16;
  localparam logic [5:0] P_ASPECT_FLAG = 6'd17;
  localparam logic [5:0] P_ASPECT_IDX  = 6'd18;
  localparam logic [5:0] P_ASPECT_NUM  = 6'd19;
  localparam logic [5:0] P_CLEAN_FLAG  = 6'd21;
  localparam logic [5:0] P_CLEAN_W     = 6'd22;
  localparam logic [5:0] P_RANGE_FLAG  = 6'd26;
  localparam logic [5:0] P_RANGE_IDX   = 6'd27;
  localparam logic [5:0] P_RANGE_OFF   = 6'd28;
  localparam logic [5:0] P_COLOUR_FLAG = 6'd32;
  localparam logic [5:0] P_COLOUR_IDX  = 6'd33;
  localparam logic [5:0] P_PRIM_FLAG   = 6'd34;
  localparam logic [5:0] P_PRIM        = 6'd35;
  localparam logic [5:0] P_MATRIX_FLAG = 6'd36;
  localparam logic [5:0] P_MATRIX      = 6'd37;
  localparam logic [5:0] P_XFER_FLAG   = 6'd38;
  localparam logic [5:0] P_XFER        = 6'd39;
  localparam logic [5:0] P_MODE        = 6'd40;
  localparam logic [5:0] P_DONE        = 6'd41;
  localparam logic [5:0] P_START = (HEADER_SKIP_BYTES > 0) ? P_SKIP : P_VERSION;

  localparam logic [31:0] MAX_FORMAT   = 32'd20;
  localparam logic [31:0] RATE_ENTRIES = 32'd11;

  localparam logic [31:0] SIZE_W [21] = '{
    32'd640, 32'd176, 32'd176, 32'd352, 32'd352, 32'd704, 32'd704, 32'd720, 32'd720,
    32'd1280, 32'd1280, 32'd1920, 32'd1920, 32'd1920, 32'd1920, 32'd2048, 32'd4096,
    32'd3840, 32'd3840, 32'd7680, 32'd7680};
  localparam logic [31:0] SIZE_H [21] = '{
    32'd480, 32'd120, 32'd144, 32'd240, 32'd288, 32'd480, 32'd576, 32'd480, 32'd576,
    32'd720, 32'd720, 32'd1080, 32'd1080, 32'd1080, 32'd1080, 32'd1080, 32'd2160,
    32'd2160, 32'd2160, 32'd4320, 32'd4320};
  localparam logic [31:0] RATE_N [11] = '{
    32'd1, 32'd24000, 32'd24, 32'd25, 32'd30000, 32'd30, 32'd50, 32'd60000, 32'd60,
    32'd15000, 32'd25};
  localparam logic [31:0] RATE_D [11] = '{
    32'd1, 32'd1001, 32'd1, 32'd1, 32'd1001, 32'd1, 32'd1, 32'd1001, 32'd1,
    32'd1001, 32'd2};
  localparam logic [3:0] FORMAT_RATE [21] = '{
    4'd1, 4'd9, 4'd10, 4'd9, 4'd10, 4'd9, 4'd10, 4'd4, 4'd3, 4'd7, 4'd6, 4'd4, 4'd3,
    4'd7, 4'd6, 4'd2, 4'd2, 4'd7, 4'd6, 4'd7, 4'd6};

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } dsh_entry_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  status;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] rate_num;
    logic [31:0] rate_den;
    logic [31:0] mode;
  } dsh_result_t;

  typedef struct packed {
    logic [5:0]  step;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] rate_num;
    logic [31:0] rate_den;
    logic [31:0] mode;
    logic [1:0]  err;
  } dsh_regs_t;

  typedef enum logic [2:0] {
    B_IDLE, B_BITS, B_FIN, B_ZERO, B_EMIT
  } dsh_state_t;

endpackage
`default_nettype wire

// ----- rtl/dsh_queue.sv -----
// Front end: small item queue between the input port and the bit parser.
// Depends on dsh_pkg.
`default_nettype none
module dsh_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire dsh_pkg::dsh_entry_t push_entry,
  output logic                     full,
  output logic                     q_valid,
  input  wire logic                q_pop,
  output dsh_pkg::dsh_entry_t      q_entry
);

  dsh_pkg::dsh_entry_t mem [dsh_pkg::QDEPTH];
  logic [dsh_pkg::QPTR_W-1:0] wp;
  logic [dsh_pkg::QPTR_W-1:0] rp;
  logic [dsh_pkg::QPTR_W:0]   cnt;
  logic                       do_push;
  logic                       do_pop;

  assign full    = (cnt == (dsh_pkg::QPTR_W+1)'(dsh_pkg::QDEPTH));
  assign q_valid = (cnt != '0);
  assign q_entry = mem[rp];
  assign do_push = push & ~full;
  assign do_pop  = q_pop & q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) wp <= wp + 1'b1;
      if (do_pop) rp <= rp + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dsh_parse.sv -----
// Back end: bit-serial header parser, one header bit per cycle while the
// queue holds data, with the end-of-data sequencer. Depends on dsh_pkg.
`default_nettype none
module dsh_parse (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  input  wire dsh_pkg::dsh_entry_t q_entry,
  output logic                     q_pop,
  input  wire logic                res_ready,
  output logic                     res_valid,
  output dsh_pkg::dsh_result_t     res
);

  dsh_pkg::dsh_state_t state, state_next;
  dsh_pkg::dsh_regs_t  regs, regs_next;
  logic [3:0]  skip_cnt, skip_cnt_next;
  logic        gphase, gphase_next;
  logic [31:0] gval, gval_next;
  logic [7:0]  sh, sh_next;
  logic [2:0]  bcnt, bcnt_next;
  logic        last_r, last_r_next;
  logic [3:0]  skip_inc;
  logic        bit_in;
  dsh_pkg::dsh_regs_t fin_regs;
  dsh_pkg::dsh_regs_t regs_init;

  function automatic logic is_flag(logic [5:0] s);
    case (s)
      dsh_pkg::P_SIZE_FLAG, dsh_pkg::P_CHROMA_FLAG, dsh_pkg::P_SCAN_FLAG,
      dsh_pkg::P_RATE_FLAG, dsh_pkg::P_ASPECT_FLAG, dsh_pkg::P_CLEAN_FLAG,
      dsh_pkg::P_RANGE_FLAG, dsh_pkg::P_COLOUR_FLAG, dsh_pkg::P_PRIM_FLAG,
      dsh_pkg::P_MATRIX_FLAG, dsh_pkg::P_XFER_FLAG: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic dsh_pkg::dsh_regs_t check_rate(dsh_pkg::dsh_regs_t r);
    dsh_pkg::dsh_regs_t n;
    n = r;
    if (r.rate_num == '0 || r.rate_den == '0) begin
      n.err  = dsh_pkg::STAT_ZERO;
      n.step = dsh_pkg::P_DONE;
    end else begin
      n.step = dsh_pkg::P_ASPECT_FLAG;
    end
    return n;
  endfunction

  // Effect of one completed field of value v on the parse registers.
  function automatic dsh_pkg::dsh_regs_t field_done(dsh_pkg::dsh_regs_t r,
                                                    logic [31:0] v);
    dsh_pkg::dsh_regs_t n;
    logic [4:0] fi;
    logic [3:0] ri;
    logic       nz;
    n  = r;
    fi = v[4:0];
    ri = v[3:0];
    nz = (v != '0);
    case (r.step)
      dsh_pkg::P_FORMAT: begin
        if (v > dsh_pkg::MAX_FORMAT) begin
          n.err  = dsh_pkg::STAT_FORMAT;
          n.step = dsh_pkg::P_DONE;
        end else begin
          n.width    = dsh_pkg::SIZE_W[fi];
          n.height   = dsh_pkg::SIZE_H[fi];
          n.rate_num = dsh_pkg::RATE_N[dsh_pkg::FORMAT_RATE[fi]];
          n.rate_den = dsh_pkg::RATE_D[dsh_pkg::FORMAT_RATE[fi]];
          n.step     = dsh_pkg::P_SIZE_FLAG;
        end
      end
      dsh_pkg::P_SIZE_FLAG:   n.step = nz ? dsh_pkg::P_WIDTH : dsh_pkg::P_CHROMA_FLAG;
      dsh_pkg::P_WIDTH: begin
        n.width = v;
        n.step  = dsh_pkg::P_HEIGHT;
      end
      dsh_pkg::P_HEIGHT: begin
        n.height = v;
        n.step   = dsh_pkg::P_CHROMA_FLAG;
      end
      dsh_pkg::P_CHROMA_FLAG: n.step = nz ? dsh_pkg::P_CHROMA : dsh_pkg::P_SCAN_FLAG;
      dsh_pkg::P_CHROMA:      n.step = dsh_pkg::P_SCAN_FLAG;
      dsh_pkg::P_SCAN_FLAG:   n.step = nz ? dsh_pkg::P_SCAN : dsh_pkg::P_RATE_FLAG;
      dsh_pkg::P_SCAN:        n.step = dsh_pkg::P_RATE_FLAG;
      dsh_pkg::P_RATE_FLAG: begin
        if (nz) n.step = dsh_pkg::P_RATE_IDX;
        else n = check_rate(r);
      end
      dsh_pkg::P_RATE_IDX: begin
        if (v >= dsh_pkg::RATE_ENTRIES) begin
          n.err  = dsh_pkg::STAT_RATE;
          n.step = dsh_pkg::P_DONE;
        end else begin
          n.rate_num = dsh_pkg::RATE_N[ri];
          n.rate_den = dsh_pkg::RATE_D[ri];
          if (!nz) n.step = dsh_pkg::P_RATE_NUM;
          else n = check_rate(n);
        end
      end
      dsh_pkg::P_RATE_NUM: begin
        n.rate_num = v;
        n.step     = dsh_pkg::P_RATE_DEN;
      end
      dsh_pkg::P_RATE_DEN: begin
        n.rate_den = v;
        n = check_rate(n);
      end
      dsh_pkg::P_ASPECT_FLAG: n.step = nz ? dsh_pkg::P_ASPECT_IDX : dsh_pkg::P_CLEAN_FLAG;
      dsh_pkg::P_ASPECT_IDX:  n.step = nz ? dsh_pkg::P_CLEAN_FLAG : dsh_pkg::P_ASPECT_NUM;
      dsh_pkg::P_CLEAN_FLAG:  n.step = nz ? dsh_pkg::P_CLEAN_W : dsh_pkg::P_RANGE_FLAG;
      dsh_pkg::P_RANGE_FLAG:  n.step = nz ? dsh_pkg::P_RANGE_IDX : dsh_pkg::P_COLOUR_FLAG;
      dsh_pkg::P_RANGE_IDX:   n.step = nz ? dsh_pkg::P_COLOUR_FLAG : dsh_pkg::P_RANGE_OFF;
      dsh_pkg::P_COLOUR_FLAG: n.step = nz ? dsh_pkg::P_COLOUR_IDX : dsh_pkg::P_MODE;
      dsh_pkg::P_COLOUR_IDX:  n.step = nz ? dsh_pkg::P_MODE : dsh_pkg::P_PRIM_FLAG;
      dsh_pkg::P_PRIM_FLAG:   n.step = nz ? dsh_pkg::P_PRIM : dsh_pkg::P_MATRIX_FLAG;
      dsh_pkg::P_MATRIX_FLAG: n.step = nz ? dsh_pkg::P_MATRIX : dsh_pkg::P_XFER_FLAG;
      dsh_pkg::P_XFER_FLAG:   n.step = nz ? dsh_pkg::P_XFER : dsh_pkg::P_MODE;
      dsh_pkg::P_MODE: begin
        n.mode = v;
        n.step = dsh_pkg::P_DONE;
      end
      default: begin
        // fields read and dropped
        if (r.step >= dsh_pkg::P_VERSION && r.step < dsh_pkg::P_DONE)
          n.step = r.step + 6'd1;
        else
          n.step = dsh_pkg::P_DONE;
      end
    endcase
    return n;
  endfunction

  assign skip_inc = skip_cnt + 4'd1;
  assign bit_in   = sh[7];

  always_comb begin
    regs_init      = '0;
    regs_init.step = dsh_pkg::P_START;
  end

  always_comb begin
    state_next  = state;
    regs_next   = regs;
    skip_cnt_next = skip_cnt;
    gphase_next = gphase;
    gval_next   = gval;
    sh_next     = sh;
    bcnt_next   = bcnt;
    last_r_next = last_r;
    q_pop       = 1'b0;
    res_valid   = 1'b0;
    fin_regs    = regs;
    case (state)
      dsh_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (regs.step == dsh_pkg::P_SKIP) begin
            skip_cnt_next = skip_inc;
            if (skip_inc >= 4'(dsh_pkg::HEADER_SKIP_BYTES) || skip_inc == 4'd0)
              regs_next.step = dsh_pkg::P_VERSION;
            state_next = q_entry.last ? dsh_pkg::B_FIN : dsh_pkg::B_IDLE;
          end else begin
            sh_next     = q_entry.data;
            bcnt_next   = '0;
            last_r_next = q_entry.last;
            state_next  = dsh_pkg::B_BITS;
          end
        end
      end
      dsh_pkg::B_BITS: begin
        sh_next   = {sh[6:0], 1'b0};
        bcnt_next = bcnt + 3'd1;
        if (regs.step != dsh_pkg::P_SKIP && regs.step < dsh_pkg::P_DONE) begin
          if (is_flag(regs.step)) begin
            regs_next = field_done(regs, {31'd0, bit_in});
          end else if (gphase) begin
            gval_next   = {gval[30:0], 1'b1} + {31'd0, bit_in};
            gphase_next = 1'b0;
          end else if (bit_in) begin
            regs_next = field_done(regs, gval);
            gval_next = '0;
          end else begin
            gphase_next = 1'b1;
          end
        end
        if (bcnt == 3'd7) begin
          if (last_r) begin
            state_next = dsh_pkg::B_FIN;
          end else if (q_valid) begin
            // next byte follows without a gap
            q_pop       = 1'b1;
            sh_next     = q_entry.data;
            bcnt_next   = '0;
            last_r_next = q_entry.last;
          end else begin
            state_next = dsh_pkg::B_IDLE;
          end
        end
      end
      dsh_pkg::B_FIN: begin
        // a header cut short while skipping starts at the first field
        if (regs.step == dsh_pkg::P_SKIP) fin_regs.step = dsh_pkg::P_VERSION;
        regs_next = fin_regs;
        if (fin_regs.step < dsh_pkg::P_DONE && !is_flag(fin_regs.step))
          regs_next = field_done(fin_regs, gphase ? {gval[30:0], 1'b1} : gval);
        gval_next   = '0;
        gphase_next = 1'b0;
        state_next  = dsh_pkg::B_ZERO;
      end
      dsh_pkg::B_ZERO: begin
        if (regs.step < dsh_pkg::P_DONE) regs_next = field_done(regs, '0);
        else state_next = dsh_pkg::B_EMIT;
      end
      dsh_pkg::B_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          regs_next      = '0;
          regs_next.step = dsh_pkg::P_START;
          skip_cnt_next  = '0;
          gval_next      = '0;
          gphase_next    = 1'b0;
          state_next     = dsh_pkg::B_IDLE;
        end
      end
      default: state_next = dsh_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    res.ok     = (regs.err == dsh_pkg::STAT_OK);
    res.status = regs.err;
    if (regs.err == dsh_pkg::STAT_OK) begin
      res.width    = regs.width;
      res.height   = regs.height;
      res.rate_num = regs.rate_num;
      res.rate_den = regs.rate_den;
      res.mode     = regs.mode;
    end else begin
      res.width    = '0;
      res.height   = '0;
      res.rate_num = '0;
      res.rate_den = '0;
      res.mode     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dsh_pkg::B_IDLE;
      regs        <= regs_init;
      skip_cnt    <= '0;
      gphase      <= 1'b0;
      gval        <= '0;
      bcnt        <= '0;
      last_r      <= 1'b0;
    end else begin
      state    <= state_next;
      regs     <= regs_next;
      skip_cnt <= skip_cnt_next;
      gphase   <= gphase_next;
      gval     <= gval_next;
      bcnt     <= bcnt_next;
      last_r   <= last_r_next;
    end
  end

  always_ff @(posedge clk) begin
    sh <= sh_next;
  end

endmodule
`default_nettype wire

// ----- rtl/dirac_sequence_header_parser.sv -----
// Top level of the sequence header parser: input queue, bit parser and
// result register. Depends on dsh_pkg, dsh_queue and dsh_parse.
`default_nettype none
// Takes one header byte per item and gives one result item on each byte
// marked last. Bytes enter a four-item queue, so the input keeps taking
// items while the parser works. The parser handles one header bit per
// cycle while the queue holds data, but takes each byte of the
// parse-info header whole; later bytes follow back to back while the
// queue holds data. After the last byte the parser finishes the remaining
// fields with zero data, then loads the result register; it starts on
// the next header while that result waits to be popped.
module dirac_sequence_header_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic             header_ok,
  output logic [1:0]       status,
  output logic [31:0]      pic_width,
  output logic [31:0]      pic_height,
  output logic [31:0]      rate_numerator,
  output logic [31:0]      rate_denominator,
  output logic [31:0]      coding_mode
);

  dsh_pkg::dsh_entry_t  push_entry;
  dsh_pkg::dsh_entry_t  q_entry;
  dsh_pkg::dsh_result_t res;
  dsh_pkg::dsh_result_t out_res;
  logic q_valid;
  logic q_pop;
  logic res_valid;
  logic res_ready;
  logic out_valid;

  assign push_entry.last = last_byte;
  assign push_entry.data = data_byte;

  dsh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_entry    (q_entry)
  );

  dsh_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  assign res_ready = ~out_valid | pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_res <= res;
  end

  assign empty            = ~out_valid;
  assign header_ok        = out_res.ok;
  assign status           = out_res.status;
  assign pic_width        = out_res.width;
  assign pic_height       = out_res.height;
  assign rate_numerator   = out_res.rate_num;
  assign rate_denominator = out_res.rate_den;
  assign coding_mode      = out_res.mode;

endmodule
`default_nettype wire

// ----- rtl/dsh_checker.sv -----
// Port-level checks for the sequence header parser, bound to the top level.
// Depends on dsh_pkg and dirac_sequence_header_parser_defines.svh.
`default_nettype none
`include "dirac_sequence_header_parser_defines.svh"
module dsh_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic        header_ok,
  input wire logic [1:0]  status,
  input wire logic [31:0] pic_width,
  input wire logic [31:0] pic_height,
  input wire logic [31:0] rate_numerator,
  input wire logic [31:0] rate_denominator,
  input wire logic [31:0] coding_mode
);

  logic status_ok;
  logic fields_zero;
  logic rate_nonzero;

  assign status_ok    = (status == dsh_pkg::STAT_OK);
  assign fields_zero  = (pic_width == '0) && (pic_height == '0) &&
                        (rate_numerator == '0) && (rate_denominator == '0) &&
                        (coding_mode == '0);
  assign rate_nonzero = (rate_numerator != '0) && (rate_denominator != '0);

  `DSH_ASSERT_ALWAYS(a_empty_after_reset, clk, rst |=> empty, "result after reset")
  `DSH_ASSERT_ON(a_ok_matches_status, clk, rst, !empty |-> (header_ok == status_ok), "ok flag off")
  `DSH_ASSERT_ON(a_error_zero_fields, clk, rst, (!empty && !status_ok) |-> fields_zero, "error data")
  `DSH_ASSERT_ON(a_ok_rate_nonzero, clk, rst, (!empty && header_ok) |-> rate_nonzero, "zero rate")
  `DSH_ASSERT_ON(a_hold_on_stall, clk, rst, (!empty && !pop) |=> (!empty && $stable(coding_mode) && $stable(status)), "item changed")

endmodule

bind dirac_sequence_header_parser dsh_checker u_dsh_checker (.*);
`default_nettype wire
